@@ hw/rtl/ntt4b_pkg.sv @@
package ntt4b_pkg;

  // widths of the stream fields
  localparam int unsigned COEF_W = 15;
  localparam int unsigned MU_W = 31;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned LANES = 4;
  localparam int unsigned IN_DATA_W = 200;
  localparam int unsigned OUT_DATA_W = 64;

  // modulus after reset
  localparam logic [COEF_W-1:0] MOD_RESET = 15'd12289;

  // internal arithmetic is 32-bit two's complement, wrapping
  typedef logic [WORD_W-1:0] word_t;

  // per-item side information that travels next to the coefficients
  typedef struct packed {
    logic op;
    logic signed [COEF_W-1:0] w_outer;
    logic signed [COEF_W-1:0] w_left;
    logic signed [COEF_W-1:0] w_right;
    logic signed [MU_W-1:0] mu_outer;
    logic signed [MU_W-1:0] mu_left;
    logic signed [MU_W-1:0] mu_right;
  } ctx_t;

  // op codes
  localparam logic OP_FORWARD = 1'b0;
  localparam logic OP_INVERSE = 1'b1;

  // sign extension of a coefficient to a word
  function automatic word_t sext_coef(input logic [COEF_W-1:0] x);
    return {{(WORD_W-COEF_W){x[COEF_W-1]}}, x};
  endfunction

  // half of the modulus as a word
  function automatic word_t half_mod(input logic [COEF_W-1:0] m);
    return {{(WORD_W-COEF_W+1){1'b0}}, m[COEF_W-1:1]};
  endfunction

  // modulus as a word
  function automatic word_t full_mod(input logic [COEF_W-1:0] m);
    return {{(WORD_W-COEF_W){1'b0}}, m};
  endfunction

  // signed test r > P/2
  function automatic logic above_half(input word_t r, input logic [COEF_W-1:0] m);
    return $signed(r) > $signed(half_mod(m));
  endfunction

endpackage

@@ hw/rtl/ntt_radix4_barrett_butterfly.sv @@
// channel     | signals                                   | carries
// ------------+-------------------------------------------+-------------------------------
// s_axis      | s_axis_tvalid/tready/tdata/tuser          | four coefficients, twiddles, Barrett constants, op
// m_axis      | m_axis_tvalid/tready/tdata                | four result coefficients
// cfg         | cfg_wr_en, cfg_wr_data                    | modulus P
//
// one group per cycle while s_axis_tready is high
// the pipeline is three Barrett multiply layers of 3 stages each, two butterfly stages and the output register
// rst clears all valid flags and sets P to 12289
// the output holds one extra result in a skid entry; s_axis_tready drops only while it is full
module ntt_radix4_barrett_butterfly (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [ntt4b_pkg::COEF_W-1:0]        cfg_wr_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // coef_a, coef_b, coef_c, coef_d, twiddle_outer, twiddle_left, twiddle_right,
  // barrett_outer, barrett_left, barrett_right, zero pad
  input  logic [ntt4b_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // op
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // res_a, res_b, res_c, res_d, zero pad
  output logic [ntt4b_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned DEPTH = 11;
  localparam int unsigned MUL_LAT = 3;
  localparam int unsigned CTX_LEN = 8;

  logic [ntt4b_pkg::COEF_W-1:0] modulus;
  logic                         en;
  logic [DEPTH-1:0]             valid_q;
  ntt4b_pkg::ctx_t              in_ctx;
  ntt4b_pkg::ctx_t              ctx_q [CTX_LEN];
  ntt4b_pkg::word_t             in_coef [ntt4b_pkg::LANES];
  ntt4b_pkg::word_t             pass1 [MUL_LAT][2];
  ntt4b_pkg::word_t             pass2 [MUL_LAT][2];
  ntt4b_pkg::word_t             pass3 [MUL_LAT][2];
  ntt4b_pkg::word_t             m1_c, m1_d, m2_b, m2_d, m3_c, m3_d;
  ntt4b_pkg::word_t             s3 [ntt4b_pkg::LANES];
  ntt4b_pkg::word_t             s4 [ntt4b_pkg::LANES];
  ntt4b_pkg::word_t             s7 [ntt4b_pkg::LANES];
  ntt4b_pkg::word_t             s8 [ntt4b_pkg::LANES];
  ntt4b_pkg::word_t             b1_ax, b1_ay, b1_bx, b1_by;
  ntt4b_pkg::word_t             b1_as, b1_ad, b1_bs, b1_bd;
  ntt4b_pkg::word_t             b2_ax, b2_ay, b2_bx, b2_by;
  ntt4b_pkg::word_t             b2_as, b2_ad, b2_bs, b2_bd;
  logic [ntt4b_pkg::OUT_DATA_W-1:0] res_data;
  logic                         in_xfer;

  // modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= ntt4b_pkg::MOD_RESET;
    end else if (cfg_wr_en) begin
      modulus <= cfg_wr_data;
    end
  end

  assign s_axis_tready = en;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // unpack the input transfer
  always_comb begin
    in_coef[0] = ntt4b_pkg::sext_coef(s_axis_tdata[14:0]);
    in_coef[1] = ntt4b_pkg::sext_coef(s_axis_tdata[29:15]);
    in_coef[2] = ntt4b_pkg::sext_coef(s_axis_tdata[44:30]);
    in_coef[3] = ntt4b_pkg::sext_coef(s_axis_tdata[59:45]);
    in_ctx.op = s_axis_tuser;
    in_ctx.w_outer = s_axis_tdata[74:60];
    in_ctx.w_left = s_axis_tdata[89:75];
    in_ctx.w_right = s_axis_tdata[104:90];
    in_ctx.mu_outer = s_axis_tdata[135:105];
    in_ctx.mu_left = s_axis_tdata[166:136];
    in_ctx.mu_right = s_axis_tdata[197:167];
  end

  // stage valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[DEPTH-2:0], s_axis_tvalid};
    end
  end

  // side information and the coefficients that skip each multiply layer
  always_ff @(posedge clk) begin
    if (en) begin
      ctx_q[0] <= in_ctx;
      for (int k = 1; k < CTX_LEN; k++) begin
        ctx_q[k] <= ctx_q[k-1];
      end
      pass1[0][0] <= in_coef[0];
      pass1[0][1] <= in_coef[1];
      pass2[0][0] <= s4[0];
      pass2[0][1] <= s4[2];
      pass3[0][0] <= s8[0];
      pass3[0][1] <= s8[1];
      for (int k = 1; k < MUL_LAT; k++) begin
        pass1[k] <= pass1[k-1];
        pass2[k] <= pass2[k-1];
        pass3[k] <= pass3[k-1];
      end
    end
  end

  // outer multiply layer, forward only
  ntt4b_bmul u_m1_c (
    .clk(clk), .en(en), .bypass(in_ctx.op == ntt4b_pkg::OP_INVERSE), .modulus(modulus),
    .a(in_coef[2]), .b(in_ctx.w_outer), .mu(in_ctx.mu_outer), .r(m1_c)
  );
  ntt4b_bmul u_m1_d (
    .clk(clk), .en(en), .bypass(in_ctx.op == ntt4b_pkg::OP_INVERSE), .modulus(modulus),
    .a(in_coef[3]), .b(in_ctx.w_outer), .mu(in_ctx.mu_outer), .r(m1_d)
  );

  // first butterfly layer: pairs by distance two forward, distance one inverse
  always_comb begin
    s3[0] = pass1[MUL_LAT-1][0];
    s3[1] = pass1[MUL_LAT-1][1];
    s3[2] = m1_c;
    s3[3] = m1_d;
    b1_ax = s3[0];
    b1_by = s3[3];
    if (ctx_q[2].op == ntt4b_pkg::OP_INVERSE) begin
      b1_ay = s3[1];
      b1_bx = s3[2];
    end else begin
      b1_ay = s3[2];
      b1_bx = s3[1];
    end
  end

  ntt4b_bfly u_b1_a (
    .clk(clk), .en(en), .modulus(modulus), .x(b1_ax), .y(b1_ay), .sum(b1_as), .diff(b1_ad)
  );
  ntt4b_bfly u_b1_b (
    .clk(clk), .en(en), .modulus(modulus), .x(b1_bx), .y(b1_by), .sum(b1_bs), .diff(b1_bd)
  );

  always_comb begin
    s4[0] = b1_as;
    s4[3] = b1_bd;
    if (ctx_q[3].op == ntt4b_pkg::OP_INVERSE) begin
      s4[1] = b1_ad;
      s4[2] = b1_bs;
    end else begin
      s4[1] = b1_bs;
      s4[2] = b1_ad;
    end
  end

  // inner multiply layer, both directions
  ntt4b_bmul u_m2_b (
    .clk(clk), .en(en), .bypass(1'b0), .modulus(modulus),
    .a(s4[1]), .b(ctx_q[3].w_left), .mu(ctx_q[3].mu_left), .r(m2_b)
  );
  ntt4b_bmul u_m2_d (
    .clk(clk), .en(en), .bypass(1'b0), .modulus(modulus),
    .a(s4[3]), .b(ctx_q[3].w_right), .mu(ctx_q[3].mu_right), .r(m2_d)
  );

  // second butterfly layer: distance one forward, distance two inverse
  always_comb begin
    s7[0] = pass2[MUL_LAT-1][0];
    s7[1] = m2_b;
    s7[2] = pass2[MUL_LAT-1][1];
    s7[3] = m2_d;
    b2_ax = s7[0];
    b2_by = s7[3];
    if (ctx_q[6].op == ntt4b_pkg::OP_INVERSE) begin
      b2_ay = s7[2];
      b2_bx = s7[1];
    end else begin
      b2_ay = s7[1];
      b2_bx = s7[2];
    end
  end

  ntt4b_bfly u_b2_a (
    .clk(clk), .en(en), .modulus(modulus), .x(b2_ax), .y(b2_ay), .sum(b2_as), .diff(b2_ad)
  );
  ntt4b_bfly u_b2_b (
    .clk(clk), .en(en), .modulus(modulus), .x(b2_bx), .y(b2_by), .sum(b2_bs), .diff(b2_bd)
  );

  always_comb begin
    s8[0] = b2_as;
    s8[3] = b2_bd;
    if (ctx_q[7].op == ntt4b_pkg::OP_INVERSE) begin
      s8[1] = b2_bs;
      s8[2] = b2_ad;
    end else begin
      s8[1] = b2_ad;
      s8[2] = b2_bs;
    end
  end

  // outer multiply layer, inverse only
  ntt4b_bmul u_m3_c (
    .clk(clk), .en(en), .bypass(ctx_q[7].op == ntt4b_pkg::OP_FORWARD), .modulus(modulus),
    .a(s8[2]), .b(ctx_q[7].w_outer), .mu(ctx_q[7].mu_outer), .r(m3_c)
  );
  ntt4b_bmul u_m3_d (
    .clk(clk), .en(en), .bypass(ctx_q[7].op == ntt4b_pkg::OP_FORWARD), .modulus(modulus),
    .a(s8[3]), .b(ctx_q[7].w_outer), .mu(ctx_q[7].mu_outer), .r(m3_d)
  );

  // merge the lanes into one result word
  assign res_data = {4'b0000, m3_d[ntt4b_pkg::COEF_W-1:0], m3_c[ntt4b_pkg::COEF_W-1:0],
                     pass3[MUL_LAT-1][1][ntt4b_pkg::COEF_W-1:0],
                     pass3[MUL_LAT-1][0][ntt4b_pkg::COEF_W-1:0]};

  ntt4b_out_buf u_out (
    .clk(clk),
    .rst(rst),
    .push(valid_q[DEPTH-1] && en),
    .push_data(res_data),
    .ready(en),
    .tvalid(m_axis_tvalid),
    .tready(m_axis_tready),
    .tdata(m_axis_tdata)
  );

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> valid_q[0])
    else $error("accepted group missing from the first stage");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(valid_q))
    else $error("pipeline moved while stalled");

  a_last_waits: assert property (@(posedge clk) disable iff (rst)
    (valid_q[DEPTH-1] && !en) |=> valid_q[DEPTH-1])
    else $error("finished group dropped during a stall");

endmodule

@@ hw/rtl/ntt4b_bmul.sv @@
module ntt4b_bmul (
  input  logic                              clk,
  input  logic                              en,
  input  logic                              bypass,
  input  logic [ntt4b_pkg::COEF_W-1:0]      modulus,
  input  ntt4b_pkg::word_t                  a,
  input  logic signed [ntt4b_pkg::COEF_W-1:0] b,
  input  logic signed [ntt4b_pkg::MU_W-1:0]   mu,
  output ntt4b_pkg::word_t                  r
);

  logic signed [ntt4b_pkg::WORD_W-1:0]   a_s;
  logic signed [ntt4b_pkg::WORD_W-1:0]   mu2_s;
  logic signed [2*ntt4b_pkg::WORD_W-1:0] wide_prod;
  ntt4b_pkg::word_t                      low_prod;
  ntt4b_pkg::word_t                      z1;
  ntt4b_pkg::word_t                      hi1;
  ntt4b_pkg::word_t                      a1;
  logic                                  byp1;
  ntt4b_pkg::word_t                      r2;
  ntt4b_pkg::word_t                      a2;
  logic                                  byp2;
  ntt4b_pkg::word_t                      r_hi;
  ntt4b_pkg::word_t                      r_lo;

  // both products of the first step
  assign a_s = $signed(a);
  assign mu2_s = $signed({mu, 1'b0});
  assign wide_prod = a_s * mu2_s;
  assign low_prod = a * ntt4b_pkg::sext_coef(b);

  always_ff @(posedge clk) begin
    if (en) begin
      z1 <= low_prod;
      hi1 <= wide_prod[2*ntt4b_pkg::WORD_W-1:ntt4b_pkg::WORD_W];
      a1 <= a;
      byp1 <= bypass;
    end
  end

  // quotient estimate times modulus, taken off the product
  always_ff @(posedge clk) begin
    if (en) begin
      r2 <= z1 - hi1 * ntt4b_pkg::full_mod(modulus);
      a2 <= a1;
      byp2 <= byp1;
    end
  end

  // upper then lower correction toward the centered range
  always_comb begin
    r_hi = ntt4b_pkg::above_half(r2, modulus) ? r2 - ntt4b_pkg::full_mod(modulus) : r2;
    r_lo = ($signed(32'd0 - ntt4b_pkg::half_mod(modulus)) > $signed(r_hi))
         ? r_hi + ntt4b_pkg::full_mod(modulus) : r_hi;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r <= byp2 ? a2 : r_lo;
    end
  end

endmodule

@@ hw/rtl/ntt4b_bfly.sv @@
module ntt4b_bfly (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ntt4b_pkg::COEF_W-1:0] modulus,
  input  ntt4b_pkg::word_t             x,
  input  ntt4b_pkg::word_t             y,
  output ntt4b_pkg::word_t             sum,
  output ntt4b_pkg::word_t             diff
);

  ntt4b_pkg::word_t s_raw;
  ntt4b_pkg::word_t d_raw;
  ntt4b_pkg::word_t s_next;
  ntt4b_pkg::word_t d_next;

  // modular add and subtract, one correction above P/2
  always_comb begin
    s_raw = x + y;
    d_raw = x - y + ntt4b_pkg::full_mod(modulus);
    s_next = ntt4b_pkg::above_half(s_raw, modulus)
           ? s_raw - ntt4b_pkg::full_mod(modulus) : s_raw;
    d_next = ntt4b_pkg::above_half(d_raw, modulus)
           ? d_raw - ntt4b_pkg::full_mod(modulus) : d_raw;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= s_next;
      diff <= d_next;
    end
  end

endmodule

@@ hw/rtl/ntt4b_out_buf.sv @@
module ntt4b_out_buf (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  logic [ntt4b_pkg::OUT_DATA_W-1:0] push_data,
  output logic                             ready,
  output logic                             tvalid,
  input  logic                             tready,
  output logic [ntt4b_pkg::OUT_DATA_W-1:0] tdata
);

  logic                             skid_valid;
  logic [ntt4b_pkg::OUT_DATA_W-1:0] skid_data;
  logic                             pop;

  // the pipeline moves only while the skid entry is free
  assign ready = !skid_valid;
  assign pop = tvalid && tready;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (tvalid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        tvalid <= 1'b1;
      end
    end else if (pop) begin
      tvalid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        tdata <= skid_data;
      end
    end else if (push) begin
      if (tvalid && !pop) begin
        skid_data <= push_data;
      end else begin
        tdata <= push_data;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> tvalid)
    else $error("skid entry held while output register is empty");

  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    (pop && !skid_valid && !push) |=> !tvalid)
    else $error("output stays valid after its transfer with nothing behind it");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && pop) |=> (tvalid && !skid_valid))
    else $error("skid entry not moved into the output register");

endmodule

@@ tb/sv/ntt_radix4_barrett_butterfly_checker.sv @@
module ntt_radix4_barrett_butterfly_checker
  import ntt4b_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [COEF_W-1:0]     cfg_wr_data,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  output int                    mismatches,
  output int                    in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RES_W = LANES * COEF_W;
  localparam int unsigned MU_LSB = 7 * COEF_W;

  // modulus as the block should hold it
  word_t mod_p;
  // predicted result groups in transfer order
  logic [RES_W-1:0] group_q[$];
  int fail_cnt = 0;
  string lane_name[4] = '{"res_a", "res_b", "res_c", "res_d"};

  // low word of a*b minus P times the high word of a*2mu, folded toward +-P/2
  function automatic word_t bar_mul(input word_t a, input word_t b, input word_t mu,
                                    input word_t p);
    word_t h, nh, z, hi, r, mu2;
    longint prod;
    h = p >> 1;
    nh = 32'd0 - h;
    z = a * b;
    mu2 = mu << 1;
    prod = longint'($signed(a)) * longint'($signed(mu2));
    hi = word_t'(prod >>> 32);
    r = z - hi * p;
    if ($signed(r) > $signed(h)) r = r - p;
    if ($signed(nh) > $signed(r)) r = r + p;
    return r;
  endfunction

  // only the upper correction, so a sum may land below -P/2
  function automatic word_t mod_add(input word_t a, input word_t b, input word_t p);
    word_t r;
    r = a + b;
    if ($signed(r) > $signed(p >> 1)) r = r - p;
    return r;
  endfunction

  function automatic word_t mod_sub(input word_t a, input word_t b, input word_t p);
    word_t r;
    r = a - b + p;
    if ($signed(r) > $signed(p >> 1)) r = r - p;
    return r;
  endfunction

  function automatic void butterfly(input word_t x, input word_t y, input word_t p,
                                    output word_t s, output word_t d);
    s = mod_add(x, y, p);
    d = mod_sub(x, y, p);
  endfunction

  // one radix-4 group, forward or inverse, from the packed input transfer
  function automatic logic [RES_W-1:0] radix4_group(input logic [IN_DATA_W-1:0] data,
                                                    input logic inv, input word_t p);
    word_t t[4];
    word_t tw[3];
    word_t mu[3];
    for (int i = 0; i < 4; i++) t[i] = int'($signed(data[i*COEF_W +: COEF_W]));
    for (int i = 0; i < 3; i++) begin
      tw[i] = int'($signed(data[(4+i)*COEF_W +: COEF_W]));
      mu[i] = int'($signed(data[MU_LSB + i*MU_W +: MU_W]));
    end
    if (inv == OP_FORWARD) begin
      t[2] = bar_mul(t[2], tw[0], mu[0], p);
      t[3] = bar_mul(t[3], tw[0], mu[0], p);
      butterfly(t[0], t[2], p, t[0], t[2]);
      butterfly(t[1], t[3], p, t[1], t[3]);
      t[1] = bar_mul(t[1], tw[1], mu[1], p);
      t[3] = bar_mul(t[3], tw[2], mu[2], p);
      butterfly(t[0], t[1], p, t[0], t[1]);
      butterfly(t[2], t[3], p, t[2], t[3]);
    end else begin
      butterfly(t[0], t[1], p, t[0], t[1]);
      butterfly(t[2], t[3], p, t[2], t[3]);
      t[1] = bar_mul(t[1], tw[1], mu[1], p);
      t[3] = bar_mul(t[3], tw[2], mu[2], p);
      butterfly(t[0], t[2], p, t[0], t[2]);
      butterfly(t[1], t[3], p, t[1], t[3]);
      t[2] = bar_mul(t[2], tw[0], mu[0], p);
      t[3] = bar_mul(t[3], tw[0], mu[0], p);
    end
    return {t[3][COEF_W-1:0], t[2][COEF_W-1:0], t[1][COEF_W-1:0], t[0][COEF_W-1:0]};
  endfunction

  // follow the modulus, predict on each input transfer, compare on each output transfer
  always @(posedge clk) begin
    logic [RES_W-1:0] want;
    logic [RES_W-1:0] got;
    logic [COEF_W-1:0] w_lane;
    logic [COEF_W-1:0] g_lane;
    if (rst) begin
      mod_p = full_mod(MOD_RESET);
      group_q.delete();
    end else begin
      if (cfg_wr_en) mod_p = full_mod(cfg_wr_data);
      if (s_axis_tvalid && s_axis_tready)
        group_q.push_back(radix4_group(s_axis_tdata, s_axis_tuser, mod_p));
      if (m_axis_tvalid && m_axis_tready) begin
        if (group_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result, expected none, got data %h", $time,
                   m_axis_tdata);
        end else begin
          want = group_q.pop_front();
          got = m_axis_tdata[RES_W-1:0];
          for (int i = 0; i < 4; i++) begin
            w_lane = want[i*COEF_W +: COEF_W];
            g_lane = got[i*COEF_W +: COEF_W];
            if (w_lane !== g_lane) begin
              fail_cnt++;
              $display("%0t: %s expected %0d got %0d", $time, lane_name[i],
                       $signed(w_lane), $signed(g_lane));
            end
          end
        end
      end
    end
    mismatches <= fail_cnt;
    in_flight <= group_q.size();
  end

endmodule

@@ tb/sv/tb_ntt_radix4_barrett_butterfly.sv @@
module tb_ntt_radix4_barrett_butterfly;
  timeunit 1ns;
  timeprecision 1ps;
  import ntt4b_pkg::*;

  localparam int CMAX = 16383;
  localparam int CMIN = -16384;
  localparam int MMAX = 1073741823;
  localparam int MMIN = -1073741824;
  localparam int ITEMS_PER_PHASE = 78;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic op;
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
    logic signed [COEF_W-1:0] d;
    logic signed [COEF_W-1:0] w_o;
    logic signed [COEF_W-1:0] w_l;
    logic signed [COEF_W-1:0] w_r;
    logic signed [MU_W-1:0] mu_o;
    logic signed [MU_W-1:0] mu_l;
    logic signed [MU_W-1:0] mu_r;
  } group_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [COEF_W-1:0] cfg_wr_data;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata;
  logic s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic calm = 1'b0;
  int mismatches;
  int in_flight;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ntt_radix4_barrett_butterfly dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  ntt_radix4_barrett_butterfly_checker checker_i (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .mismatches(mismatches),
    .in_flight(in_flight)
  );

  // residue in [-P/2, P/2]
  function automatic int centered(input int p);
    return int'($urandom_range(0, 2 * (p / 2))) - p / 2;
  endfunction

  // Barrett constant round-toward-zero of w * 2^31 / P
  function automatic int barrett_of(input int w, input int p);
    longint m;
    m = (longint'(w) * 64'sd2147483648) / longint'(p);
    return int'(m);
  endfunction

  function automatic group_t make_group(input logic op, input int a, input int b,
                                        input int c, input int d, input int wo,
                                        input int wl, input int wr, input int mo,
                                        input int ml, input int mr);
    group_t g;
    g.op = op;
    g.a = COEF_W'(a);
    g.b = COEF_W'(b);
    g.c = COEF_W'(c);
    g.d = COEF_W'(d);
    g.w_o = COEF_W'(wo);
    g.w_l = COEF_W'(wl);
    g.w_r = COEF_W'(wr);
    g.mu_o = MU_W'(mo);
    g.mu_l = MU_W'(ml);
    g.mu_r = MU_W'(mr);
    return g;
  endfunction

  // centered coefficients and twiddles with matching Barrett constants
  function automatic group_t well_formed(input int p);
    group_t g;
    g.op = $urandom_range(0, 1) ? OP_INVERSE : OP_FORWARD;
    g.a = COEF_W'(centered(p));
    g.b = COEF_W'(centered(p));
    g.c = COEF_W'(centered(p));
    g.d = COEF_W'(centered(p));
    g.w_o = COEF_W'(centered(p));
    g.w_l = COEF_W'(centered(p));
    g.w_r = COEF_W'(centered(p));
    g.mu_o = MU_W'(barrett_of(int'(g.w_o), p));
    g.mu_l = MU_W'(barrett_of(int'(g.w_l), p));
    g.mu_r = MU_W'(barrett_of(int'(g.w_r), p));
    return g;
  endfunction

  // one input transfer, with an occasional idle burst ahead of it
  task automatic push(input group_t g);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, g.mu_r, g.mu_l, g.mu_o, g.w_r, g.w_l, g.w_o,
                     g.d, g.c, g.b, g.a};
    s_axis_tuser <= g.op;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // stop sending and wait until the pipeline is empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_modulus(input int p);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= COEF_W'(p);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // output side back-pressure in bursts
  initial begin
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  initial begin
    #400000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int p;
    int h;
    int mods[7];
    group_t g;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed groups at the reset modulus
    p = int'(MOD_RESET);
    h = p / 2;
    push(make_group(OP_FORWARD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    push(make_group(OP_INVERSE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // field extremes, far outside the centered range and with wrong constants
    push(make_group(OP_FORWARD, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
                    MMAX, MMAX, MMAX));
    push(make_group(OP_INVERSE, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX,
                    MMAX, MMAX, MMAX));
    push(make_group(OP_FORWARD, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                    MMIN, MMIN, MMIN));
    push(make_group(OP_INVERSE, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN,
                    MMIN, MMIN, MMIN));
    // edges of the centered range; at -P/2 the sums fall below -P/2
    push(make_group(OP_FORWARD, h, h, h, h, h, h, h, barrett_of(h, p),
                    barrett_of(h, p), barrett_of(h, p)));
    push(make_group(OP_INVERSE, -h, -h, -h, -h, -h, -h, -h, barrett_of(-h, p),
                    barrett_of(-h, p), barrett_of(-h, p)));
    push(make_group(OP_FORWARD, -h, -h, -h, -h, -h, -h, -h, barrett_of(-h, p),
                    barrett_of(-h, p), barrett_of(-h, p)));
    // unit and zero twiddles
    push(make_group(OP_FORWARD, 5, -7, 11, -13, 1, 1, 1, barrett_of(1, p),
                    barrett_of(1, p), barrett_of(1, p)));
    push(make_group(OP_INVERSE, 5, -7, 11, -13, 1, 1, 1, barrett_of(1, p),
                    barrett_of(1, p), barrett_of(1, p)));
    push(make_group(OP_FORWARD, 1234, -4321, 99, -1, 0, 0, 0, 0, 0, 0));
    // mixed extremes with random constants
    push(make_group(OP_INVERSE, CMAX, CMIN, 0, -1, CMIN, CMAX, 0,
                    int'($urandom), int'($urandom), int'($urandom)));
    for (int i = 0; i < 6; i++) push(well_formed(p));
    settle();

    // modulus phases, the last one without idling
    mods = '{3329, 3, 32767, 4, 7681, 0, 12289};
    mods[5] = int'(2 * $urandom_range(2, 16383) + 1);
    for (int ph = 0; ph < 7; ph++) begin
      p = mods[ph];
      calm = (ph == 6);
      set_modulus(p);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 4) == 0) begin
          // noise over every bit of every field
          g.op = $urandom_range(0, 1) ? OP_INVERSE : OP_FORWARD;
          g.a = COEF_W'($urandom);
          g.b = COEF_W'($urandom);
          g.c = COEF_W'($urandom);
          g.d = COEF_W'($urandom);
          g.w_o = COEF_W'($urandom);
          g.w_l = COEF_W'($urandom);
          g.w_r = COEF_W'($urandom);
          g.mu_o = MU_W'($urandom);
          g.mu_l = MU_W'($urandom);
          g.mu_r = MU_W'($urandom);
        end else begin
          g = well_formed(p);
        end
        push(g);
      end
      settle();
    end

    if (mismatches == 0 && in_flight == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/ntt4b_pkg.sv
hw/rtl/ntt4b_bmul.sv
hw/rtl/ntt4b_bfly.sv
hw/rtl/ntt4b_out_buf.sv
hw/rtl/ntt_radix4_barrett_butterfly.sv
tb/sv/ntt_radix4_barrett_butterfly_checker.sv
tb/sv/tb_ntt_radix4_barrett_butterfly.sv
